### rtl/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg: shared types and constants
// Widths, defaults and the per-node cell interface used by the solver.
// ----------------------------------------------------------------------------
package apsp_pkg;

    localparam int DEF_MAX_NODES = 8;
    localparam int DEF_MAX_EDGES = 64;
    localparam int NODE_W        = 3;
    localparam int WEIGHT_W      = 16;
    localparam int DIST_W        = 24;
    localparam int CNT_W         = 4;
    localparam int ACC_W         = 26;

    // Operations that the sequencer broadcasts to every cell.
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_BF_INIT = 3'd1;
    localparam logic [2:0] OP_RELAX   = 3'd2;
    localparam logic [2:0] OP_DJ_INIT = 3'd3;
    localparam logic [2:0] OP_SETTLE  = 3'd4;

    typedef struct packed {
        logic [2:0]          op;
        logic [NODE_W-1:0]   node_a;
        logic [NODE_W-1:0]   node_b;
        logic signed [ACC_W-1:0] cand;
    } cell_cmd_t;

endpackage

### rtl/apsp_cell.sv
// ----------------------------------------------------------------------------
// apsp_cell: one node of the distance chain
// Holds the potential and the current row distance of a single node and
// answers init, relaxation and settle requests broadcast by the sequencer.
// ----------------------------------------------------------------------------
module apsp_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  apsp_pkg::cell_cmd_t               cmd,
    input  logic                              in_use,
    output logic                              pot_known,
    output logic signed [apsp_pkg::ACC_W-1:0] pot,
    output logic                              row_known,
    output logic                              settled,
    output logic signed [apsp_pkg::ACC_W-1:0] row_dist,
    output logic                              changed
);
    import apsp_pkg::*;

    logic                     pk_reg, rk_reg, st_reg;
    logic signed [ACC_W-1:0]  pot_reg, dist_reg;
    logic                     hit;

    assign hit = (cmd.node_b == NODE_W'(IDX)) && in_use;

    always_comb
    begin
        changed = 1'b0;
        if (cmd.op == OP_RELAX && hit && (!pk_reg || cmd.cand < pot_reg))
            changed = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_reg <= 1'b0;
            rk_reg <= 1'b0;
            st_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_BF_INIT:
                begin
                    pk_reg  <= 1'b0;
                end
                OP_RELAX:
                begin
                    if (changed)
                    begin
                        pk_reg  <= 1'b1;
                        pot_reg <= cmd.cand;
                    end
                end
                OP_DJ_INIT:
                begin
                    st_reg   <= 1'b0;
                    rk_reg   <= (cmd.node_a == NODE_W'(IDX));
                    dist_reg <= '0;
                end
                OP_SETTLE:
                begin
                    // node_a is settled; cand holds its distance plus the edge to us
                    if (cmd.node_a == NODE_W'(IDX))
                        st_reg <= 1'b1;
                    else if (hit && !st_reg && (!rk_reg || cmd.cand < dist_reg))
                    begin
                        rk_reg   <= 1'b1;
                        dist_reg <= cmd.cand;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign pot_known = pk_reg;
    assign pot       = pot_reg;
    assign row_known = rk_reg;
    assign settled   = st_reg;
    assign row_dist  = dist_reg;

endmodule

### rtl/all_pairs_shortest_paths.sv
// An edge beat without tlast is stored. A tlast beat starts the solve:
// Bellman-Ford for the potentials, a pass over the edges to build the
// matrix, then per source a Dijkstra run (S_RDM and S_UPD per matrix
// read) and V output beats.
// Throughput: one edge per cycle while loading; one graph at a time.
// Reset: asynchronous, active low; empty store, node_count = 8, idle.
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths: Johnson all-pairs shortest paths solver
// Stores edges, finds potentials, runs Dijkstra per source and streams pairs.
// ----------------------------------------------------------------------------
module all_pairs_shortest_paths #(
    parameter int MAX_NODES = apsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = apsp_pkg::DEF_MAX_EDGES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // edge_from[2:0], edge_to[5:3], edge_weight[21:6], zero [23:22]
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pair_from[2:0], pair_to[5:3], path_length[29:6], reachable[30], zero[31]
    output logic [31:0] m_axis_tdata,
    // negative_cycle
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import apsp_pkg::*;

    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int MW  = 2 * NODE_W;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_BFE_RD = 4'd1;
    localparam logic [3:0] S_BFE    = 4'd2;
    localparam logic [3:0] S_BFV    = 4'd3;
    localparam logic [3:0] S_MX_RD  = 4'd4;
    localparam logic [3:0] S_MX     = 4'd5;
    localparam logic [3:0] S_DJ_INI = 4'd6;
    localparam logic [3:0] S_SEL    = 4'd7;
    localparam logic [3:0] S_RDM    = 4'd8;
    localparam logic [3:0] S_UPD    = 4'd9;
    localparam logic [3:0] S_OUT    = 4'd10;
    localparam logic [3:0] S_NEG    = 4'd11;
    localparam logic [3:0] S_CLR    = 4'd12;

    logic [3:0]        state_reg;
    logic [3:0]        ncfg_reg;
    logic [ECW-1:0]    held_reg;
    logic [ECW-1:0]    eidx_reg;
    logic [CNT_W-1:0]  iter_reg, src_reg, j_reg, cnt_reg;
    logic [NODE_W-1:0] u_reg;
    logic              any_reg;
    logic              neg_reg;
    logic [(1 << MW)-1:0] present_reg;

    logic [2*NODE_W+WEIGHT_W-1:0] estore [MAX_EDGES];
    logic [2*NODE_W+WEIGHT_W-1:0] erd_reg;
    logic signed [ACC_W-1:0]      mstore [1 << MW];
    logic signed [ACC_W-1:0]      mrd_reg;

    logic [CNT_W-1:0] v;
    always_comb
    begin
        v = ncfg_reg;
        if (v == '0)
            v = CNT_W'(1);
        if (32'(v) > MAX_NODES)
            v = CNT_W'(MAX_NODES);
    end

    // Cells
    cell_cmd_t cmd;
    logic [MAX_NODES-1:0] pk, rk, st, chg;
    logic signed [ACC_W-1:0] pot [MAX_NODES];
    logic signed [ACC_W-1:0] row_dist [MAX_NODES];

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++)
        begin : g_cell
            apsp_cell #(.IDX(g)) u_cell (
                .clk(clk), .rst_n(rst_n), .cmd(cmd),
                .in_use(32'(g) < 32'(v)),
                .pot_known(pk[g]), .pot(pot[g]), .row_known(rk[g]),
                .settled(st[g]), .row_dist(row_dist[g]), .changed(chg[g])
            );
        end
    endgenerate

    // Edge fields from the store read register
    logic [NODE_W-1:0] ea, eb;
    logic signed [WEIGHT_W-1:0] ew;
    logic e_ok;
    assign ea = erd_reg[NODE_W-1:0];
    assign eb = erd_reg[2*NODE_W-1:NODE_W];
    assign ew = erd_reg[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    assign e_ok = ({1'b0, ea} < v) && ({1'b0, eb} < v);

    logic [NODE_W-1:0] jn, sn;
    assign jn = j_reg[NODE_W-1:0];
    assign sn = src_reg[NODE_W-1:0];

    // Linear minimum selection, one node per cycle
    logic sel_take;
    always_comb
    begin
        sel_take = 1'b0;
        if (!st[jn])
        begin
            if (!any_reg)
                sel_take = 1'b1;
            else if (rk[jn] && (!rk[u_reg] || row_dist[jn] < row_dist[u_reg]))
                sel_take = 1'b1;
        end
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_BFE:
            begin
                if (eidx_reg != '0 && e_ok && pk[ea])
                begin
                    cmd.op     = OP_RELAX;
                    cmd.node_b = eb;
                    cmd.cand   = pot[ea] + ACC_W'(ew);
                end
            end
            S_BFV:
            begin
                // virtual source is known at potential zero
                cmd.op     = OP_RELAX;
                cmd.node_b = jn;
                cmd.cand   = '0;
            end
            S_DJ_INI:
            begin
                cmd.op     = OP_DJ_INIT;
                cmd.node_a = sn;
            end
            S_UPD:
            begin
                cmd.op     = OP_SETTLE;
                cmd.node_a = u_reg;
                cmd.node_b = present_reg[{u_reg, jn}] ? jn : u_reg;
                cmd.cand   = row_dist[u_reg] + mrd_reg;
            end
            S_CLR:
            begin
                cmd.op = OP_BF_INIT;
            end
            default:
            begin
            end
        endcase
    end

    logic s_acc, m_acc, last_in_iter;
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == S_LOAD);
    assign last_in_iter = (iter_reg == v);

    always_ff @(posedge clk)
    begin
        if (s_acc && held_reg < ECW'(MAX_EDGES))
            estore[held_reg[EW-1:0]] <= s_axis_tdata[2*NODE_W+WEIGHT_W-1:0];
        erd_reg <= estore[eidx_reg[EW-1:0]];
        if (state_reg == S_MX && eidx_reg != '0 && e_ok)
            mstore[{ea, eb}] <= ACC_W'(ew) + pot[ea] - pot[eb];
        mrd_reg <= mstore[{u_reg, jn}];
    end

    logic signed [ACC_W-1:0] res_d;
    assign res_d = row_dist[jn] - pot[sn] + pot[jn];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            ncfg_reg    <= 4'd8;
            held_reg    <= '0;
            eidx_reg    <= '0;
            iter_reg    <= '0;
            src_reg     <= '0;
            j_reg       <= '0;
            cnt_reg     <= '0;
            u_reg       <= '0;
            any_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            present_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                ncfg_reg <= cfg_wdata;
            case (state_reg)
                S_LOAD:
                begin
                    if (s_acc)
                    begin
                        if (held_reg < ECW'(MAX_EDGES))
                            held_reg <= held_reg + 1'b1;
                        if (s_axis_tlast)
                            state_reg <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    iter_reg  <= '0;
                    neg_reg   <= 1'b0;
                    eidx_reg  <= '0;
                    state_reg <= S_BFE_RD;
                end
                S_BFE_RD:
                begin
                    // eidx 0 primes the read register; edge i is in use at eidx i+1
                    eidx_reg  <= ECW'(1);
                    state_reg <= S_BFE;
                end
                S_BFE:
                begin
                    if (last_in_iter && |chg)
                        neg_reg <= 1'b1;
                    if (eidx_reg == held_reg || eidx_reg == '0 && held_reg == '0)
                    begin
                        j_reg     <= '0;
                        state_reg <= S_BFV;
                    end
                    else
                        eidx_reg <= eidx_reg + 1'b1;
                end
                S_BFV:
                begin
                    if (last_in_iter && |chg)
                        neg_reg <= 1'b1;
                    if (j_reg + 1'b1 == v)
                    begin
                        eidx_reg <= '0;
                        if (last_in_iter)
                            state_reg <= (neg_reg || |chg) ? S_NEG : S_MX_RD;
                        else
                        begin
                            iter_reg  <= iter_reg + 1'b1;
                            state_reg <= S_BFE_RD;
                        end
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_MX_RD:
                begin
                    present_reg <= '0;
                    eidx_reg    <= ECW'(1);
                    state_reg   <= S_MX;
                end
                S_MX:
                begin
                    if (eidx_reg != '0 && e_ok)
                        present_reg[{ea, eb}] <= 1'b1;
                    if (eidx_reg >= held_reg)
                    begin
                        src_reg   <= '0;
                        state_reg <= S_DJ_INI;
                    end
                    else
                        eidx_reg <= eidx_reg + 1'b1;
                end
                S_DJ_INI:
                begin
                    cnt_reg   <= '0;
                    j_reg     <= '0;
                    any_reg   <= 1'b0;
                    state_reg <= (v == CNT_W'(1)) ? S_OUT : S_SEL;
                end
                S_SEL:
                begin
                    if (sel_take)
                    begin
                        u_reg   <= jn;
                        any_reg <= 1'b1;
                    end
                    if (j_reg + 1'b1 == v)
                    begin
                        j_reg <= '0;
                        if (!(any_reg || sel_take) ||
                            (sel_take ? !rk[jn] : !rk[u_reg]))
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_RDM;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_RDM:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (j_reg + 1'b1 == v)
                    begin
                        j_reg   <= '0;
                        any_reg <= 1'b0;
                        cnt_reg <= cnt_reg + 1'b1;
                        state_reg <= (cnt_reg + CNT_W'(2) == v) ? S_OUT : S_SEL;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_RDM;
                    end
                end
                S_OUT:
                begin
                    if (m_acc)
                    begin
                        if (j_reg + 1'b1 == v)
                        begin
                            j_reg <= '0;
                            if (src_reg + 1'b1 == v)
                            begin
                                held_reg  <= '0;
                                state_reg <= S_LOAD;
                            end
                            else
                            begin
                                src_reg   <= src_reg + 1'b1;
                                state_reg <= S_DJ_INI;
                            end
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                    end
                end
                S_NEG:
                begin
                    if (m_acc)
                    begin
                        held_reg  <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    logic neg_out;
    assign neg_out = (state_reg == S_NEG);
    assign m_axis_tvalid = (state_reg == S_OUT) || neg_out;
    assign m_axis_tuser  = neg_out;
    assign m_axis_tlast  = neg_out || ((j_reg + 1'b1 == v) && (src_reg + 1'b1 == v));
    assign m_axis_tdata  = neg_out ? 32'd0 :
        {1'b0, rk[jn], (rk[jn] ? res_d[DIST_W-1:0] : DIST_W'(0)), jn, sn};

endmodule

### rtl/apsp_checker.sv
// ----------------------------------------------------------------------------
// apsp_checker: port-level checks for the solver
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module apsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);
    // No new edge is taken while results are being delivered.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while results pending");

    // A negative cycle beat is the only and last beat of its run.
    a_neg_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 32'd0))
        else $error("negative cycle beat malformed");

    // Unreachable pairs carry a zero length.
    a_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[30]) |-> (m_axis_tdata[29:6] == 24'd0))
        else $error("unreachable pair with nonzero length");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind all_pairs_shortest_paths apsp_checker u_apsp_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: all-pairs shortest paths solver testbench
// Streams edge graphs into the solver, predicts every distance pair with an
// independent Johnson solve and compares each output beat in order.
// ----------------------------------------------------------------------------
module tb_top;

    import apsp_pkg::*;

    localparam int MAXN = 8;
    localparam int MAXE = 64;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic [2:0]         pair_from;
        logic [2:0]         pair_to;
        logic signed [23:0] path_length;
        logic               reachable;
        logic               negative_cycle;
        logic               last_result;
    } pair_result_t;

    // Predicts the solver and holds the distances still to come out.
    class distance_board;
        logic [2:0]   e_from [MAXE];
        logic [2:0]   e_to [MAXE];
        longint       e_wt [MAXE];
        int           held;
        int           nodes;
        pair_result_t pending [$];
        int           errors;

        function new();
            held = 0;
            nodes = 8;
            errors = 0;
        endfunction

        function void set_nodes(logic [3:0] value);
            nodes = value;
        endfunction

        function void note_edge(logic [2:0] f, logic [2:0] t,
                                logic signed [15:0] w, logic lst);
            if (held < MAXE)
            begin
                e_from[held] = f;
                e_to[held] = t;
                e_wt[held] = w;
                held++;
            end
            if (lst)
            begin
                solve_graph();
                held = 0;
            end
        endfunction

        function void solve_graph();
            int           v;
            longint       pot [MAXN+1];
            bit           pk [MAXN+1];
            longint       mat [MAXN][MAXN];
            bit           mp [MAXN][MAXN];
            longint       row_d [MAXN];
            bit           dk [MAXN];
            bit           done [MAXN];
            bit           neg;
            int           u;
            longint       c;
            pair_result_t r;
            v = (nodes == 0) ? 1 : (nodes > MAXN ? MAXN : nodes);
            foreach (pk[i])
            begin
                pk[i] = 0;
                pot[i] = 0;
            end
            pk[v] = 1;
            neg = 0;
            // v rounds of relaxation, then one more sweep as the cycle check
            for (int it = 0; it <= v; it++)
            begin
                for (int i = 0; i < held; i++)
                    if (e_from[i] < v && e_to[i] < v && pk[e_from[i]] &&
                        (!pk[e_to[i]] || pot[e_from[i]] + e_wt[i] < pot[e_to[i]]))
                    begin
                        pot[e_to[i]] = pot[e_from[i]] + e_wt[i];
                        pk[e_to[i]] = 1;
                        if (it == v)
                            neg = 1;
                    end
                if (it == v && neg)
                    break;
                for (int i = 0; i < v; i++)
                    if (!pk[i] || 0 < pot[i])
                    begin
                        pot[i] = 0;
                        pk[i] = 1;
                        if (it == v)
                            neg = 1;
                    end
            end
            if (neg)
            begin
                r = '{3'd0, 3'd0, 24'sd0, 1'b0, 1'b1, 1'b1};
                pending.push_back(r);
                return;
            end
            foreach (mp[a, b])
                mp[a][b] = 0;
            for (int i = 0; i < held; i++)
                if (e_from[i] < v && e_to[i] < v)
                begin
                    mat[e_from[i]][e_to[i]] = e_wt[i] + pot[e_from[i]] - pot[e_to[i]];
                    mp[e_from[i]][e_to[i]] = 1;
                end
            for (int s = 0; s < v; s++)
            begin
                foreach (dk[j])
                begin
                    dk[j] = 0;
                    row_d[j] = 0;
                    done[j] = 0;
                end
                dk[s] = 1;
                for (int it = 0; it + 1 < v; it++)
                begin
                    u = -1;
                    for (int j = 0; j < v; j++)
                    begin
                        if (done[j])
                            continue;
                        if (u < 0)
                            u = j;
                        else if (dk[j] && (!dk[u] || row_d[j] < row_d[u]))
                            u = j;
                    end
                    if (u < 0 || !dk[u])
                        break;
                    done[u] = 1;
                    for (int j = 0; j < v; j++)
                        if (!done[j] && mp[u][j])
                        begin
                            c = row_d[u] + mat[u][j];
                            if (!dk[j] || c < row_d[j])
                            begin
                                row_d[j] = c;
                                dk[j] = 1;
                            end
                        end
                end
                for (int t = 0; t < v; t++)
                begin
                    r.pair_from = 3'(s);
                    r.pair_to = 3'(t);
                    r.path_length = dk[t] ? 24'(row_d[t] - pot[s] + pot[t]) : 24'sd0;
                    r.reachable = dk[t];
                    r.negative_cycle = 0;
                    r.last_result = (s == v - 1 && t == v - 1);
                    pending.push_back(r);
                end
            end
        endfunction

        function void check_pair(logic [31:0] data, logic user, logic lst);
            pair_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat: data %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.pair_from)
            begin
                $error("pair_from: expected %0d, got %0d", e.pair_from, data[2:0]);
                errors++;
            end
            if (data[5:3] !== e.pair_to)
            begin
                $error("pair_to: expected %0d, got %0d", e.pair_to, data[5:3]);
                errors++;
            end
            if (data[29:6] !== e.path_length)
            begin
                $error("path_length: expected %0d, got %0d",
                       e.path_length, $signed(data[29:6]));
                errors++;
            end
            if (data[30] !== e.reachable)
            begin
                $error("reachable: expected %0b, got %0b", e.reachable, data[30]);
                errors++;
            end
            if (user !== e.negative_cycle)
            begin
                $error("negative_cycle: expected %0b, got %0b", e.negative_cycle, user);
                errors++;
            end
            if (lst !== e.last_result)
            begin
                $error("last_result: expected %0b, got %0b", e.last_result, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    distance_board board;
    longint        cycles;
    bit            calm;
    bit            hold_off;

    all_pairs_shortest_paths i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side: checks every accepted beat and stalls in bursts.
    initial
    begin
        int gap;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_axis_tready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 18);
                m_axis_tready <= 0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready <= 1;
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_pair(m_axis_tdata, m_axis_tuser, m_axis_tlast);

    task automatic write_nodes(input logic [3:0] value);
        @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 0;
        board.set_nodes(value);
    endtask

    // Called at a falling edge; a non-final beat leaves tvalid high for the next one.
    task automatic send_edge(input logic [2:0] f, input logic [2:0] t,
                             input logic signed [15:0] w, input logic lst);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {2'b00, w, t, f};
        s_axis_tlast <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_edge(f, t, w, lst);
        @(negedge clk);
        if (lst)
            s_axis_tvalid <= 0;
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    // Random graph; mostly small non-negative weights, with odd extremes.
    task automatic random_graph(input int n_edges, input int span);
        logic signed [15:0] w;
        for (int i = 0; i < n_edges; i++)
        begin
            case ($urandom_range(0, 9))
                0: w = 16'($urandom);
                1: w = -$signed(16'($urandom_range(0, 20)));
                default: w = 16'($urandom_range(0, 300));
            endcase
            send_edge(3'($urandom_range(0, span)), 3'($urandom_range(0, span)), w,
                      i == n_edges - 1);
        end
    endtask

    initial
    begin
        int sent;
        board = new();
        calm = 0;
        hold_off = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        rst_n = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: default eight nodes with extreme weights and a self loop.
        send_edge(3'd0, 3'd7, 16'sh7FFF, 0);
        send_edge(3'd7, 3'd1, 16'sh8000, 0);
        send_edge(3'd0, 3'd7, 16'sd5, 0);
        send_edge(3'd3, 3'd3, 16'sd0, 1);
        wait_drained();
        // Negative cycle.
        write_nodes(4'd3);
        send_edge(3'd0, 3'd1, 16'sd2, 0);
        send_edge(3'd1, 3'd0, -16'sd3, 1);
        wait_drained();
        // Edge outside the node range, node count zero, count above the maximum.
        send_edge(3'd5, 3'd6, -16'sd100, 0);
        send_edge(3'd0, 3'd2, 16'sd9, 1);
        wait_drained();
        write_nodes(4'd0);
        send_edge(3'd0, 3'd0, 16'sd4, 1);
        wait_drained();
        write_nodes(4'd15);
        send_edge(3'd1, 3'd2, -16'sd1, 1);
        wait_drained();
        write_nodes(4'd1);
        send_edge(3'd7, 3'd0, 16'sd1, 1);
        wait_drained();
        // Overfull store: the extra edges are dropped, the tlast one still solves.
        write_nodes(4'd8);
        for (int i = 0; i < 70; i++)
            send_edge(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      16'($urandom_range(0, 1000)), i == 69);
        wait_drained();

        // A long receiver hold-off while the sender keeps offering a second graph.
        hold_off = 1;
        fork
            begin
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
        join_none
        random_graph(10, 7);
        random_graph(10, 7);
        wait_drained();

        sent = 0;
        while (sent < 250)
        begin
            int ne;
            if (sent > 200)
                calm = 1;
            if ($urandom_range(0, 2) == 0)
            begin
                write_nodes(4'($urandom_range(1, 8)));
                wait_drained();
            end
            ne = $urandom_range(1, 14);
            random_graph(ne, $urandom_range(0, 3) == 0 ? 7 : board.nodes - 1);
            sent += ne;
            wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/apsp_pkg.sv
rtl/apsp_cell.sv
rtl/all_pairs_shortest_paths.sv
rtl/apsp_checker.sv
tb/sv/tb_top.sv
